// ===== src/ps2hb_pkg.sv =====
package ps2hb_pkg;

    // item kinds carried on the slave tuser
    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_TICK = 2'd1,
        OP_SEND = 2'd2
    } t_op;

    // configuration register indexes
    localparam logic CFG_AT_MODE = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [3:0]  FRAME_AT   = 4'd11;
    localparam logic [3:0]  FRAME_XT   = 4'd10;
    localparam logic [3:0]  TX_BITS    = 4'd11;
    localparam logic [10:0] TX_FILL    = 11'h600;
    localparam logic [15:0] GAP_MAX    = 16'hffff;
    localparam logic [1:0]  DRIVE_IDLE = 2'd3;
    localparam logic [1:0]  DRIVE_RTS  = 2'd2;
    localparam logic [1:0]  DRIVE_REL  = 2'd2;

    typedef struct packed {
        logic [10:0] shift_frame;
        logic [3:0]  bit_count;
        logic        sending;
        logic [15:0] gap_ticks;
    } t_link_state;

    typedef struct packed {
        logic       send_rejected;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [1:0] drive_lines;
        logic       drive_valid;
    } t_result;

endpackage

// ===== src/ps2hb_step.sv =====
module ps2hb_step (
    input  ps2hb_pkg::t_link_state i_state,
    input  logic                   i_at_mode,
    input  logic [15:0]            i_timeout_ticks,
    input  ps2hb_pkg::t_op         i_operation,
    input  logic                   i_data_line,
    input  logic [7:0]             i_send_byte,
    output ps2hb_pkg::t_link_state o_state,
    output ps2hb_pkg::t_result     o_result
);

    logic        late;
    logic [3:0]  frame_len;
    logic [3:0]  next_count;
    logic [10:0] rx_frame;
    logic [3:0]  rx_count;
    logic        tx_bit;

    assign late      = i_state.gap_ticks > i_timeout_ticks;
    assign frame_len = i_at_mode ? ps2hb_pkg::FRAME_AT : ps2hb_pkg::FRAME_XT;

    always_comb begin
        o_state    = i_state;
        o_result   = '0;
        next_count = i_state.bit_count + 4'd1;
        tx_bit     = 1'b0;
        rx_frame   = i_state.shift_frame;
        rx_count   = i_state.bit_count;
        case (i_operation)
            ps2hb_pkg::OP_EDGE: begin
                if (i_state.sending) begin
                    if (i_state.bit_count != 4'd0 &&
                        (i_state.bit_count >= ps2hb_pkg::TX_BITS || late)) begin
                        // stalled transmit: let go of the lines, gap timing untouched
                        o_state.shift_frame  = '0;
                        o_state.bit_count    = '0;
                        o_state.sending      = 1'b0;
                        o_result.drive_valid = 1'b1;
                        o_result.drive_lines = ps2hb_pkg::DRIVE_IDLE;
                    end else begin
                        if (i_state.bit_count < ps2hb_pkg::TX_BITS) begin
                            tx_bit = i_state.shift_frame[i_state.bit_count];
                        end
                        o_result.drive_valid = 1'b1;
                        o_result.drive_lines = ps2hb_pkg::DRIVE_REL | {1'b0, tx_bit};
                        o_state.bit_count    = next_count;
                        if (next_count >= ps2hb_pkg::TX_BITS) begin
                            o_state.shift_frame  = '0;
                            o_state.bit_count    = '0;
                            o_state.sending      = 1'b0;
                            o_result.drive_lines = ps2hb_pkg::DRIVE_IDLE;
                        end
                        o_state.gap_ticks = '0;
                    end
                end else begin
                    if (i_state.bit_count >= frame_len || late) begin
                        rx_frame = '0;
                        rx_count = '0;
                    end
                    rx_frame = rx_frame | (11'({i_data_line}) << rx_count);
                    rx_count = rx_count + 4'd1;
                    o_state.shift_frame = rx_frame;
                    o_state.bit_count   = rx_count;
                    if (rx_count == frame_len) begin
                        o_result.rx_valid = 1'b1;
                        o_result.rx_byte  = i_at_mode ? rx_frame[8:1] : rx_frame[9:2];
                    end
                    o_state.gap_ticks = '0;
                end
            end
            ps2hb_pkg::OP_TICK: begin
                if (i_state.gap_ticks < ps2hb_pkg::GAP_MAX) begin
                    o_state.gap_ticks = i_state.gap_ticks + 16'd1;
                end
            end
            ps2hb_pkg::OP_SEND: begin
                if (!i_at_mode) begin
                    o_result.send_rejected = 1'b1;
                end else begin
                    o_state.bit_count    = '0;
                    o_state.sending      = 1'b1;
                    o_state.shift_frame  = ps2hb_pkg::TX_FILL |
                                           {2'b00, ~(^i_send_byte), i_send_byte};
                    o_result.drive_valid = 1'b1;
                    o_result.drive_lines = ps2hb_pkg::DRIVE_RTS;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/ps2_host_bitbang_engine.sv =====
// host side of an at/xt keyboard link. every slave transfer is one event:
// a keyboard clock edge with its sampled data bit, a time tick, or a byte
// to send; every event gives exactly one master transfer. the link state is
// updated in the cycle the event is taken and the result lands in an output
// register, so one event is taken per clock as long as the output side keeps
// up; an event is accepted while a result is still waiting only if that
// result leaves in the same cycle. master tvalid rises in the cycle after the
// slave transfer. configuration writes take effect on the next clock and
// are meant to be made while the link is idle.
module ps2_host_bitbang_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // event stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,    // [0] data_line, [8:1] send_byte, rest zero
    input  logic [1:0]  i_s_tuser,    // [1:0] operation
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata     // [0] drive_valid, [2:1] drive_lines,
                                      // [3] rx_valid, [11:4] rx_byte,
                                      // [12] send_rejected, rest zero
);

    // configuration registers
    logic        r_at_mode;
    logic [15:0] r_timeout;

    // link state and the result register
    ps2hb_pkg::t_link_state r_state, n_state;
    ps2hb_pkg::t_result     r_result, n_result;
    logic                   r_m_valid;

    logic s_take;

    // the output register frees up when empty or when its transfer completes
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_take     = i_s_tvalid && o_s_tready;

    ps2hb_step u_step (
        .i_state         (r_state),
        .i_at_mode       (r_at_mode),
        .i_timeout_ticks (r_timeout),
        .i_operation     (ps2hb_pkg::t_op'(i_s_tuser)),
        .i_data_line     (i_s_tdata[0]),
        .i_send_byte     (i_s_tdata[8:1]),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_mode <= 1'b1;
            r_timeout <= 16'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ps2hb_pkg::CFG_AT_MODE: r_at_mode <= i_cfg_data[0];
                ps2hb_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // link state advances once per accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s_take) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, r_result};

`ifndef SYNTHESIS
    // a transmit never sits beyond its last bit
    a_tx_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sending |-> (r_state.bit_count < ps2hb_pkg::TX_BITS))
        else $error("transmit bit count out of range");

    // one event reports at most one of a drive update, a received byte or a refusal
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($countones({r_result.drive_valid, r_result.rx_valid,
                                    r_result.send_rejected}) <= 1))
        else $error("result carries more than one kind of report");

    // a send taken in at mode starts a transmit and requests to send
    a_send_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_take && i_s_tuser == ps2hb_pkg::OP_SEND && r_at_mode && !i_cfg_we)
        |=> (r_state.sending && r_state.bit_count == 4'd0 &&
             r_result.drive_lines == ps2hb_pkg::DRIVE_RTS))
        else $error("send request did not start a transmit");
`endif

endmodule

// ===== tb/tb_ps2hb_scoreboard_pkg.sv =====
`timescale 1ns / 100ps

package ps2_link_check_pkg;

    class link_scoreboard;
        // register copies
        logic        at_sel;
        logic [15:0] timeout_lim;
        // link state copies
        logic [10:0] frame_bits;
        logic [3:0]  bit_idx;
        logic        tx_busy;
        logic [15:0] gap_count;

        ps2hb_pkg::t_result awaited[$];
        int                 mismatch_count;

        function new();
            at_sel         = 1'b1;
            timeout_lim    = 16'd10;
            frame_bits     = '0;
            bit_idx        = '0;
            tx_busy        = 1'b0;
            gap_count      = '0;
            mismatch_count = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == ps2hb_pkg::CFG_AT_MODE) begin
                at_sel = value[0];
            end else begin
                timeout_lim = value;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void drop_frame();
            frame_bits = '0;
            bit_idx    = '0;
        endfunction

        // advance the link by one event and return the line/receive outcome
        function ps2hb_pkg::t_result step_link(logic [1:0] op, logic dbit, logic [7:0] sbyte);
            ps2hb_pkg::t_result r;
            logic               late;
            logic [3:0]         frame_len;
            r    = '0;
            late = (gap_count > timeout_lim);
            case (op)
                ps2hb_pkg::OP_EDGE: begin
                    if (tx_busy) begin
                        if (bit_idx != 0 && (bit_idx >= ps2hb_pkg::TX_BITS || late)) begin
                            // transmit timed out, release and keep the gap count
                            drop_frame();
                            tx_busy       = 1'b0;
                            r.drive_valid = 1'b1;
                            r.drive_lines = ps2hb_pkg::DRIVE_IDLE;
                        end else begin
                            r.drive_valid = 1'b1;
                            r.drive_lines = ps2hb_pkg::DRIVE_REL |
                                {1'b0, (bit_idx < ps2hb_pkg::TX_BITS) ?
                                       frame_bits[bit_idx] : 1'b0};
                            bit_idx = bit_idx + 4'd1;
                            if (bit_idx >= ps2hb_pkg::TX_BITS) begin
                                drop_frame();
                                tx_busy       = 1'b0;
                                r.drive_lines = ps2hb_pkg::DRIVE_IDLE;
                            end
                            gap_count = '0;
                        end
                    end else begin
                        frame_len = at_sel ? ps2hb_pkg::FRAME_AT : ps2hb_pkg::FRAME_XT;
                        if (bit_idx >= frame_len || late) begin
                            drop_frame();
                        end
                        if (bit_idx < 4'd11) begin
                            frame_bits[bit_idx] = frame_bits[bit_idx] | dbit;
                        end
                        bit_idx = bit_idx + 4'd1;
                        if (bit_idx == frame_len) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = at_sel ? frame_bits[8:1] : frame_bits[9:2];
                        end
                        gap_count = '0;
                    end
                end
                ps2hb_pkg::OP_TICK: begin
                    if (gap_count != ps2hb_pkg::GAP_MAX) begin
                        gap_count = gap_count + 16'd1;
                    end
                end
                ps2hb_pkg::OP_SEND: begin
                    if (!at_sel) begin
                        r.send_rejected = 1'b1;
                    end else begin
                        bit_idx       = '0;
                        tx_busy       = 1'b1;
                        frame_bits    = ps2hb_pkg::TX_FILL | {2'b00, ~^sbyte, sbyte};
                        r.drive_valid = 1'b1;
                        r.drive_lines = ps2hb_pkg::DRIVE_RTS;
                    end
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_event(logic [1:0] op, logic dbit, logic [7:0] sbyte);
            awaited.push_back(step_link(op, dbit, sbyte));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [15:0] tdata);
            ps2hb_pkg::t_result got;
            ps2hb_pkg::t_result want;
            got = ps2hb_pkg::t_result'(tdata[12:0]);
            if (awaited.size() == 0) begin
                $error("result 0x%04h arrived with nothing outstanding", tdata);
                mismatch_count++;
                return;
            end
            want = awaited.pop_front();
            compare_field("drive_valid", 8'(want.drive_valid), 8'(got.drive_valid));
            compare_field("drive_lines", 8'(want.drive_lines), 8'(got.drive_lines));
            compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("send_rejected", 8'(want.send_rejected), 8'(got.send_rejected));
        endfunction
    endclass

endpackage

// ===== tb/tb_ps2_host_bitbang_engine.sv =====
`timescale 1ns / 100ps

module tb_ps2_host_bitbang_engine;

    // operation code the block must ignore
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    // receiver hold-off length, counted in the receiver process
    localparam int         HOLD_CYCLES    = 300;
    // cycles with no transfer on either side before the run is abandoned
    localparam int         WATCHDOG_LIMIT = 4000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    ps2_link_check_pkg::link_scoreboard sb;

    // sender burst state and current register settings as seen by the generator
    int   burst_left  = 0;
    int   items_sent  = 0;
    logic cur_at      = 1'b1;
    int   cur_timeout = 10;

    // receiver stall state
    logic hold_flag   = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   stall_mode  = 0;
    int   seg_left    = 0;
    int   cyc_count   = 0;
    int   idle_cycles = 0;

    ps2_host_bitbang_engine uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // single reset pulse at the start of the run
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // transfer monitor: results are checked before the event of the same edge is noted
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_event(s_tuser, s_tdata[0], s_tdata[8:1]);
            end
        end
    end

    // receiver: segments of differing stall patterns, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_flag;
            hold_left <= 0;
            seg_left  <= 0;
        end else if (hold_seen != hold_flag) begin
            hold_seen <= hold_flag;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                seg_left   <= $urandom_range(16, 128);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) < 60);
                2: m_tready <= (cyc_count % 4 == 0);
                default: m_tready <= (cyc_count % 7 != 3);
            endcase
        end
    end

    // watchdog: any transfer restarts the count
    always @(posedge clk) begin
        cyc_count <= cyc_count + 1;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one event and wait for its transfer; gaps fall between random bursts
    task automatic push_event(input logic [1:0] op, input logic dbit, input logic [7:0] sbyte);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, sbyte, dbit};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic push_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            push_event(ps2hb_pkg::OP_TICK, 1'($urandom), 8'($urandom));
        end
    endtask

    // tick count between edges that stays within the timeout
    function automatic int quiet_gap();
        int k;
        k = $urandom_range(0, 3);
        if (k > cur_timeout) begin
            k = cur_timeout;
        end
        return k;
    endfunction

    // keyboard clock edges carrying bits lsb first, short gaps between them
    task automatic push_edges(input logic [11:0] bits, input int count);
        for (int i = 0; i < count; i++) begin
            if (i != 0) begin
                push_ticks(quiet_gap());
            end
            push_event(ps2hb_pkg::OP_EDGE, bits[i], 8'($urandom));
        end
    endtask

    // wait until every expected result has arrived, sender quiet
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // both registers, written back to back while the link is idle
    task automatic apply_setting(input logic at, input int tmo);
        cfg_we    <= 1'b1;
        cfg_index <= ps2hb_pkg::CFG_AT_MODE;
        cfg_data  <= {15'd0, at};
        @(posedge clk);
        cfg_index <= ps2hb_pkg::CFG_TIMEOUT;
        cfg_data  <= 16'(tmo);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(ps2hb_pkg::CFG_AT_MODE, {15'd0, at});
        sb.set_reg(ps2hb_pkg::CFG_TIMEOUT, 16'(tmo));
        cur_at      = at;
        cur_timeout = tmo;
    endtask

    // receive frame, sometimes cut short; a long pause ahead of it realigns small timeouts
    task automatic rx_frame();
        logic [11:0] bits;
        int          len;
        int          cut;
        bits = 12'($urandom);
        len  = cur_at ? 11 : 10;
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
        if (cur_timeout < 64 && $urandom_range(0, 1) == 1) begin
            push_ticks(cur_timeout + 1);
        end
        push_edges(bits, cut);
    endtask

    // host send; in at mode followed by a whole, a cut short or an overlong run of edges
    task automatic tx_frame();
        int nedges;
        push_event(ps2hb_pkg::OP_SEND, 1'($urandom), 8'($urandom));
        if (cur_at) begin
            case ($urandom_range(0, 9))
                0:       nedges = $urandom_range(1, 10);
                1:       nedges = 12;
                default: nedges = 11;
            endcase
            push_edges(12'($urandom), nedges);
            // edge after an overlong pause while still transmitting
            if (nedges < 11 && cur_timeout < 64 && $urandom_range(0, 1) == 1) begin
                push_ticks(cur_timeout + 1);
                push_event(ps2hb_pkg::OP_EDGE, 1'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic run_phase(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                rx_frame();
            end else if (pick < 65) begin
                tx_frame();
            end else if (pick < 80) begin
                push_ticks($urandom_range(1, 20));
            end else if (pick < 90) begin
                push_event(ps2hb_pkg::OP_EDGE, 1'($urandom), 8'($urandom));
            end else if (pick < 95) begin
                push_event(OP_UNUSED, 1'($urandom), 8'($urandom));
            end else begin
                push_event(ps2hb_pkg::OP_SEND, 1'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        @(posedge rst_n);
        @(posedge clk);

        // directed: ignored code, a tick, a full send of zero, then an at frame of 0xff
        push_event(OP_UNUSED, 1'b1, 8'hff);
        push_event(ps2hb_pkg::OP_TICK, 1'b0, 8'h00);
        push_event(ps2hb_pkg::OP_SEND, 1'b0, 8'h00);
        push_edges(12'h555, 11);
        push_edges({1'b0, 1'b1, 1'b1, 8'hff, 1'b0}, 11);
        drain_results(2);

        // receiver holds off while the sender keeps offering
        hold_flag <= ~hold_flag;
        run_phase(100);
        drain_results(2);

        // largest timeout, then a long gap that still never times out
        apply_setting(1'b1, 65535);
        run_phase(80);
        push_ticks(70);
        rx_frame();
        drain_results(2);

        apply_setting(1'b0, 1);
        run_phase(80);
        drain_results(2);

        // zero timeout: any tick between edges restarts
        apply_setting(1'b1, 0);
        run_phase(80);
        drain_results(2);

        apply_setting(1'b0, 65535);
        run_phase(80);
        drain_results(2);

        apply_setting(1'b1, 1);
        run_phase(80);
        drain_results(2);

        apply_setting(1'b1, $urandom_range(2, 40));
        run_phase(80);
        drain_results(2);

        apply_setting(1'b0, $urandom_range(0, 40));
        run_phase(80);
        drain_results(4);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
